// ===== hw/rtl/serial_frame_receiver_crc16_unit_macros.svh =====
// Assertion macros for the checker file
`ifndef SERIAL_FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SFR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// Next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

// Next-cycle implication, checked during reset as well
`define SFR_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sfr reset assertion failed");

`endif

// ===== hw/rtl/sfr_pkg.sv =====
package sfr_pkg;

    localparam int BufferBytes = 256;
    localparam int CntW        = $clog2(BufferBytes);
    localparam int LenW        = 17;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);

    localparam logic [15:0] CrcPoly = 16'hA001;
    localparam logic [7:0]  SyncB0  = 8'hAA;
    localparam logic [7:0]  SyncB1  = 8'h55;
    localparam logic [7:0]  SyncB2  = 8'h01;
    localparam logic [LenW-1:0] LenBase = 17'd22;
    localparam int          HdrDonePos = 19;
    localparam int          CapFirst   = 15;

    localparam logic [1:0] StGood   = 2'd0;
    localparam logic [1:0] StCrcErr = 2'd1;
    localparam logic [1:0] StOvf    = 2'd2;

    typedef struct packed {
        logic is_aa;
        logic is_55;
        logic is_01;
    } t_cls;

    typedef struct packed {
        logic [7:0] data;
        t_cls       cls;
    } t_qent;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/sfr_front.sv =====
module sfr_front
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    output logic       o_q_valid,
    output t_qent      o_q_ent,
    input  logic       i_q_pop
);

    t_qent              r_mem [QDepth];
    logic [QPtrW-1:0]   r_wptr, n_wptr;
    logic [QPtrW-1:0]   r_rptr, n_rptr;
    logic [QPtrW:0]     r_cnt, n_cnt;
    logic               push;
    logic               pop;
    t_qent              ent;

    assign o_s_tready = (r_cnt != (QPtrW+1)'(QDepth));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_ent    = r_mem[r_rptr];

    always_comb begin
        ent.data      = i_s_tdata;
        ent.cls.is_aa = (i_s_tdata == SyncB0);
        ent.cls.is_55 = (i_s_tdata == SyncB1);
        ent.cls.is_01 = (i_s_tdata == SyncB2);
        n_wptr = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = pop ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= ent;
        end
    end

endmodule

// ===== hw/rtl/sfr_back.sv =====
module sfr_back
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_qent       i_q_ent,
    output logic        o_q_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser
);

    logic [CntW-1:0] r_cnt, n_cnt;
    logic [LenW-1:0] r_len, n_len;
    logic [7:0]      r_prev0, n_prev0, r_prev1, n_prev1;
    logic [7:0]      r_hdr0, n_hdr0, r_hdr1, n_hdr1, r_hdr2, n_hdr2;
    logic [7:0]      r_cap0, n_cap0, r_cap1, n_cap1, r_cap2, n_cap2, r_cap3, n_cap3;
    logic [15:0]     r_crc, n_crc;
    logic            r_o_valid;
    logic [47:0]     r_o_data, n_o_data;
    logic            r_o_last, n_o_last;
    logic [1:0]      r_o_user, n_o_user;

    logic            pop;
    logic            resync;
    logic [CntW-1:0] pos;
    logic [CntW-1:0] cnt_inc;
    logic [7:0]      b;
    logic [15:0]     received;

    assign pop        = i_q_valid && (!r_o_valid || i_m_tready);
    assign o_q_pop    = pop;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_user;

    always_comb begin
        b        = i_q_ent.data;
        received = {r_prev0, b};
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_prev0  = r_prev0;
        n_prev1  = r_prev1;
        n_hdr0   = r_hdr0;
        n_hdr1   = r_hdr1;
        n_hdr2   = r_hdr2;
        n_cap0   = r_cap0;
        n_cap1   = r_cap1;
        n_cap2   = r_cap2;
        n_cap3   = r_cap3;
        n_crc    = r_crc;
        n_o_last = 1'b0;
        n_o_user = StGood;
        cnt_inc  = '0;

        resync = i_q_ent.cls.is_01 && (r_cnt >= CntW'(2)) &&
                 (r_prev0 == SyncB1) && (r_prev1 == SyncB0);
        pos = r_cnt;
        if (resync) begin
            n_len  = '0;
            n_hdr0 = SyncB0;
            n_hdr1 = SyncB1;
            pos    = CntW'(2);
        end

        n_o_data = {16'h0000, 8'h00, 8'h00, 8'(pos), b};

        if (pos < CntW'(BufferBytes - 1)) begin
            n_crc = (pos < CntW'(4)) ? 16'h0000 : crc_fold(r_crc, r_prev1);
            if (pos == CntW'(0)) n_hdr0 = b;
            if (pos == CntW'(1)) n_hdr1 = b;
            if (pos == CntW'(2)) n_hdr2 = b;
            if (pos == CntW'(CapFirst))     n_cap0 = b;
            if (pos == CntW'(CapFirst + 1)) n_cap1 = b;
            if (pos == CntW'(CapFirst + 2)) n_cap2 = b;
            if (pos == CntW'(CapFirst + 3)) n_cap3 = b;
            n_prev1 = r_prev0;
            n_prev0 = b;
            cnt_inc = pos + 1'b1;
            n_cnt   = cnt_inc;
            if ((cnt_inc == CntW'(HdrDonePos)) && (n_hdr0 == SyncB0) &&
                (n_hdr1 == SyncB1) && (n_hdr2 == SyncB2)) begin
                n_len = LenBase + LenW'({n_cap2, n_cap3});
            end
            if (LenW'(cnt_inc) == n_len) begin
                n_o_last = 1'b1;
                n_o_user = (received == n_crc) ? StGood : StCrcErr;
                n_o_data = {n_cap2, n_cap3, n_cap1, n_cap0, 8'(pos), b};
                n_cnt    = '0;
                n_len    = '0;
            end
        end else begin
            n_o_last = 1'b1;
            n_o_user = StOvf;
            n_cnt    = '0;
            n_len    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_len     <= '0;
            r_prev0   <= '0;
            r_prev1   <= '0;
            r_hdr0    <= '0;
            r_hdr1    <= '0;
            r_hdr2    <= '0;
            r_cap0    <= '0;
            r_cap1    <= '0;
            r_cap2    <= '0;
            r_cap3    <= '0;
            r_crc     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_cnt   <= n_cnt;
                r_len   <= n_len;
                r_prev0 <= n_prev0;
                r_prev1 <= n_prev1;
                r_hdr0  <= n_hdr0;
                r_hdr1  <= n_hdr1;
                r_hdr2  <= n_hdr2;
                r_cap0  <= n_cap0;
                r_cap1  <= n_cap1;
                r_cap2  <= n_cap2;
                r_cap3  <= n_cap3;
                r_crc   <= n_crc;
            end
            if (pop) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_o_data <= n_o_data;
            r_o_last <= n_o_last;
            r_o_user <= n_o_user;
        end
    end

endmodule

// ===== hw/rtl/serial_frame_receiver_crc16_unit.sv =====
// Framed serial byte receiver with CRC-16/ARC check.
// Slave stream: one received byte per transfer on i_s_tdata.
// Master stream: one result per input byte, in order. o_m_tdata carries the
// echoed byte, its frame index, and flag, command and size of a finished frame
// (zero otherwise). o_m_tlast marks a byte that ends a frame or overflowed;
// o_m_tuser gives the status then (good, CRC error, overflow), zero otherwise.
// Throughput: one byte per cycle while the receiver takes results; the
// per-byte frame update and the byte-wide CRC step are combinational
// logic in the back end. Each byte is written into the queue on its transfer
// edge, and the back end registers its result when it pops that byte.
// A four-entry queue sits between the input side and the frame logic, so the
// input keeps taking bytes while a result waits on a stalled receiver; once
// the queue fills, o_s_tready drops until the receiver takes results again.
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending
// result and clears the frame state: count, length, CRC and held bytes.
module serial_frame_receiver_crc16_unit
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] data_byte, [15:8] byte_index, [23:16] flag_byte,
    // [31:24] command_code, [47:32] payload_size
    output logic [47:0] o_m_tdata,
    output logic        o_m_tlast,   // frame_done
    output logic [1:0]  o_m_tuser    // [1:0] frame_status
);

    logic  q_valid;
    t_qent q_ent;
    logic  q_pop;

    sfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_q_valid  (q_valid),
        .o_q_ent    (q_ent),
        .i_q_pop    (q_pop)
    );

    sfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_ent    (q_ent),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== hw/rtl/sfr_checker.sv =====
`include "serial_frame_receiver_crc16_unit_macros.svh"

module sfr_checker
    import sfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [1:0]  o_m_tuser
);

    `SFR_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))

    `SFR_ASSERT_IMPL(a_status_only_at_end, o_m_tvalid && !o_m_tlast, o_m_tuser == StGood)

    `SFR_ASSERT_IMPL(a_overflow_fields_zero, o_m_tvalid && o_m_tuser == StOvf, o_m_tlast && o_m_tdata[47:16] == 32'd0)

    `SFR_ASSERT_IMPL(a_midframe_fields_zero, o_m_tvalid && !o_m_tlast, o_m_tdata[47:16] == 32'd0)

    `SFR_ASSERT_RST(a_reset_empty, !i_rst_n, !o_m_tvalid && o_s_tready)

endmodule

bind serial_frame_receiver_crc16_unit sfr_checker u_sfr_checker (.*);
